// ===== src/secd_pkg.sv =====
// types, constants and helper functions for the seven-bit escape decoder
`timescale 1ns / 1ps

package secd_pkg;

  // transaction payloads
  typedef struct packed {
    logic       start_req;
    logic [7:0] link_char;
  } in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] running_sum;
  } out_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_BYTE     = 3'd0,
    STAT_CONSUMED = 3'd1,
    STAT_MATCH    = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_CORRUPT  = 3'd4,
    STAT_ENDED    = 3'd5
  } status_e;

  // run state, one-hot
  typedef enum logic [2:0] {
    RUN_ACTIVE  = 3'b001,
    RUN_ENDED   = 3'b010,
    RUN_CORRUPT = 3'b100
  } run_e;

  // pending prefix codes, one per prefix character 0172..0176
  typedef enum logic [2:0] {
    PFX_NONE = 3'd0,
    PFX_172  = 3'd1,
    PFX_173  = 3'd2,
    PFX_174  = 3'd3,
    PFX_175  = 3'd4,
    PFX_176  = 3'd5
  } prefix_e;

  // trailer phases
  typedef enum logic [2:0] {
    TRL_IDLE   = 3'd0,
    TRL_DIGIT1 = 3'd1,
    TRL_DIGIT2 = 3'd2,
    TRL_DIGIT3 = 3'd3,
    TRL_DIGIT4 = 3'd4,
    TRL_CR     = 3'd5
  } trailer_e;

  localparam logic [15:0] SUM_INIT      = 16'hffff;
  localparam logic [6:0]  CHAR_PFX_LOW  = 7'o172;
  localparam logic [6:0]  CHAR_PFX_HIGH = 7'o176;
  localparam logic [6:0]  CHAR_SPACE    = 7'o040;
  localparam logic [6:0]  CHAR_CR       = 7'h0d;

  // offset added to a printable character for each prefix
  function automatic logic [7:0] prefix_offset(input prefix_e p);
    logic [7:0] off;
    case (p)
      PFX_172: off = 8'hc0;  // minus 0100
      PFX_173: off = 8'h40;
      PFX_174: off = 8'h40;
      PFX_175: off = 8'h80;
      PFX_176: off = 8'hc0;
      default: off = 8'h00;
    endcase
    return off;
  endfunction

  // hex digit decode, bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [6:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 7'h30 && c <= 7'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 7'h61 && c <= 7'h66) || (c >= 7'h41 && c <= 7'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== src/secd_if.sv =====
// valid/ready channel interfaces for the decoder input and result streams
`timescale 1ns / 1ps

interface secd_in_if;
  logic          valid;
  logic          ready;
  secd_pkg::in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface secd_out_if;
  logic           valid;
  logic           ready;
  secd_pkg::out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/seven_bit_escape_decoder_checksum.sv =====
// top level: seven-bit escape decoder with trailer checksum compare
//
//   channel  dir  payload                              transaction
//   in_i     in   start_req, link_char                 one link character or start
//   out_o    out  data_byte, status, running_sum       one result per input
//
// every input transaction produces exactly one result transaction
// decode, checksum rotate-add and trailer compare run combinationally between
// the parse state registers and a two-entry result buffer (output + skid)
// one character per cycle while in_i.ready is high; each result is registered in the output or skid entry
// rst_ni clears the parse state to the start-of-transfer state
// in_i.ready drops only while both result entries are full
`timescale 1ns / 1ps

module seven_bit_escape_decoder_checksum (
  input  logic              clk_i,
  input  logic              rst_ni,
  secd_in_if.sink           in_i,
  secd_out_if.source        out_o
);

  // parse state
  logic [15:0]        sum_q, sum_d;
  logic [15:0]        rx_sum_q, rx_sum_d;
  secd_pkg::prefix_e  pfx_q, pfx_d;
  secd_pkg::trailer_e trl_q, trl_d;
  secd_pkg::run_e     run_q, run_d;

  // result buffer
  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  secd_pkg::out_t out_q, out_d;
  secd_pkg::out_t skid_q, skid_d;

  logic           in_fire, out_fire;
  logic [6:0]     ch;
  logic [4:0]     hex;
  logic [7:0]     data;
  secd_pkg::status_e stat;
  secd_pkg::out_t res;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;
  assign ch       = in_i.payload.link_char[6:0];  // bit 7 is dropped
  assign hex      = secd_pkg::hex_digit(ch);

  // one character of decode
  always_comb begin
    sum_d    = sum_q;
    rx_sum_d = rx_sum_q;
    pfx_d    = pfx_q;
    trl_d    = trl_q;
    run_d    = run_q;
    stat     = secd_pkg::STAT_CONSUMED;
    data     = {1'b0, ch} + secd_pkg::prefix_offset(pfx_q);

    if (in_i.payload.start_req) begin
      // new transfer, character ignored
      sum_d    = secd_pkg::SUM_INIT;
      rx_sum_d = '0;
      pfx_d    = secd_pkg::PFX_NONE;
      trl_d    = secd_pkg::TRL_IDLE;
      run_d    = secd_pkg::RUN_ACTIVE;
    end else if (run_q == secd_pkg::RUN_ENDED) begin
      stat = secd_pkg::STAT_ENDED;
    end else if (run_q != secd_pkg::RUN_ACTIVE) begin
      stat = secd_pkg::STAT_CORRUPT;
    end else if (trl_q != secd_pkg::TRL_IDLE) begin
      if (trl_q != secd_pkg::TRL_CR) begin
        // hex digit of the trailer
        if (!hex[4]) begin
          stat  = secd_pkg::STAT_CORRUPT;
          run_d = secd_pkg::RUN_CORRUPT;
          pfx_d = secd_pkg::PFX_NONE;
          trl_d = secd_pkg::TRL_IDLE;
        end else begin
          rx_sum_d = {rx_sum_q[11:0], hex[3:0]};
          trl_d    = secd_pkg::trailer_e'(trl_q + 3'd1);
        end
      end else begin
        // closing carriage return, then compare
        if (ch != secd_pkg::CHAR_CR) begin
          stat  = secd_pkg::STAT_CORRUPT;
          run_d = secd_pkg::RUN_CORRUPT;
          pfx_d = secd_pkg::PFX_NONE;
          trl_d = secd_pkg::TRL_IDLE;
        end else begin
          stat  = (rx_sum_q == sum_q) ? secd_pkg::STAT_MATCH : secd_pkg::STAT_MISMATCH;
          run_d = secd_pkg::RUN_ENDED;
          trl_d = secd_pkg::TRL_IDLE;
        end
      end
    end else if (ch >= secd_pkg::CHAR_PFX_LOW) begin
      if (pfx_q != secd_pkg::PFX_NONE) begin
        // prefix after prefix: only 0176 is legal and it opens the trailer
        pfx_d = secd_pkg::PFX_NONE;
        if (ch != secd_pkg::CHAR_PFX_HIGH) begin
          stat  = secd_pkg::STAT_CORRUPT;
          run_d = secd_pkg::RUN_CORRUPT;
          trl_d = secd_pkg::TRL_IDLE;
        end else begin
          trl_d    = secd_pkg::TRL_DIGIT1;
          rx_sum_d = '0;
        end
      end else begin
        pfx_d = secd_pkg::prefix_e'(ch[2:0] - 3'd1);  // 0172 -> 1 ... 0176 -> 5
      end
    end else if (ch < secd_pkg::CHAR_SPACE) begin
      // control character outside the trailer
      stat  = secd_pkg::STAT_CORRUPT;
      run_d = secd_pkg::RUN_CORRUPT;
      pfx_d = secd_pkg::PFX_NONE;
      trl_d = secd_pkg::TRL_IDLE;
    end else begin
      // printable data character: rotate left by one, add byte
      sum_d = {sum_q[14:0], sum_q[15]} + {8'd0, data};
      pfx_d = secd_pkg::PFX_NONE;
      stat  = secd_pkg::STAT_BYTE;
    end

    res.data_byte   = (stat == secd_pkg::STAT_BYTE) ? data : 8'd0;
    res.status      = stat;
    res.running_sum = sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= secd_pkg::SUM_INIT;
      rx_sum_q <= '0;
      pfx_q    <= secd_pkg::PFX_NONE;
      trl_q    <= secd_pkg::TRL_IDLE;
      run_q    <= secd_pkg::RUN_ACTIVE;
    end else if (in_fire) begin
      sum_q    <= sum_d;
      rx_sum_q <= rx_sum_d;
      pfx_q    <= pfx_d;
      trl_q    <= trl_d;
      run_q    <= run_d;
    end
  end

  // two-entry result buffer: the skid entry keeps input flowing while
  // the output entry is stalled
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;

    if (out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end

    if (in_fire) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_i.ready    = ~skid_valid_q;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
